[rtl/core/kufm_pkg.sv]
// ============================================================================
// kufm_pkg: shared types and constants for the union-find spanning tree block
// Holds the request and result payload types, the parent table access
// bundle, the sequencer state type and the sizing constants.
// ============================================================================
package kufm_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 7;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int WEIGHT_W  = 16;
    localparam int COST_W    = 22;

    localparam logic [COST_W-1:0] COST_MAX    = {COST_W{1'b1}};
    localparam logic [NODE_W-1:0] RESET_NODES = NODE_W'(64);

    typedef struct packed {
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                last_edge;
    } edge_t;

    typedef struct packed {
        logic              edge_taken;
        logic              tree_complete;
        logic [COST_W-1:0] running_cost;
        logic [COST_W-1:0] final_cost;
        logic              is_final;
    } result_t;

    // Access bundle from the sequencer to the parent table.
    typedef struct packed {
        logic [NODE_W-1:0] rd_node;
        logic              wr_en;
        logic [NODE_W-1:0] wr_node;
        logic [NODE_W-1:0] wr_parent;
        logic              clear;
    } tbl_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND_ISSUE,
        ST_FIND_WALK,
        ST_COMP_ISSUE,
        ST_COMP_WALK,
        ST_UNION,
        ST_OUTPUT
    } ctrl_state_t;

endpackage

[rtl/core/kufm_table.sv]
// ============================================================================
// kufm_table: parent table of the union-find structure
// One write port and one registered read port over a node-indexed memory.
// Per-entry valid bits make an unwritten entry read as its own node number.
// ============================================================================
module kufm_table
    import kufm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_req_t          req,
    output logic [NODE_W-1:0] parent
);

    logic [NODE_W-1:0]    mem [MAX_NODES];
    logic [MAX_NODES-1:0] valid_reg;
    logic [NODE_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;

    // Node numbers start at 1, table entries at 0.
    assign rd_idx = IDX_W'(req.rd_node - NODE_W'(1));
    assign wr_idx = IDX_W'(req.wr_node - NODE_W'(1));

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_idx] <= req.wr_parent;
        end
        rd_data_reg <= mem[rd_idx];
        rd_idx_reg  <= rd_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_idx];
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    assign parent = rd_valid_reg ? rd_data_reg
                                 : NODE_W'(rd_idx_reg) + NODE_W'(1);

endmodule

[rtl/core/kufm_ctrl.sv]
// ============================================================================
// kufm_ctrl: sequencer for root search, path compression and union
// Walks both parent chains one hop per cycle through the shared compare,
// compresses them, joins the roots and keeps the cost and tree counters.
// ============================================================================
module kufm_ctrl
    import kufm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NODE_W-1:0] cfg_data,
    input  logic              edge_valid,
    output logic              edge_ready,
    input  edge_t             edge_req,
    input  logic              slot_free,
    output logic              res_load,
    output result_t           res_data,
    output tbl_req_t          tbl_req,
    input  logic [NODE_W-1:0] tbl_parent
);

    ctrl_state_t       state_reg, state_next;
    logic [NODE_W-1:0] node_count_reg, node_count_next;
    logic [NODE_W-1:0] nodes_left_reg, nodes_left_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic              done_reg, done_next;
    edge_t             item_reg, item_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] root_reg, root_next;
    logic [NODE_W-1:0] root_a_reg, root_a_next;
    logic              side_reg, side_next;
    logic              taken_reg, taken_next;

    logic [NODE_W-1:0] eff_cur;
    logic [NODE_W-1:0] eff_cfg;
    logic              cfg_we;
    logic              in_range;
    logic [COST_W:0]   cost_sum;
    logic [NODE_W-1:0] left_dec;

    // A count of zero acts as one node, any count above the table size as full size.
    function automatic logic [NODE_W-1:0] eff_nodes(input logic [NODE_W-1:0] cnt);
        logic [NODE_W-1:0] r;
        begin
            if (cnt == '0)
                r = NODE_W'(1);
            else if (cnt > NODE_W'(MAX_NODES))
                r = NODE_W'(MAX_NODES);
            else
                r = cnt;
            return r;
        end
    endfunction

    assign eff_cur   = eff_nodes(node_count_reg);
    assign eff_cfg   = eff_nodes(cfg_data);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_range  = (edge_req.from_node != '0) && (edge_req.from_node <= eff_cur) &&
                       (edge_req.to_node != '0) && (edge_req.to_node <= eff_cur);
    assign cost_sum  = {1'b0, cost_reg} + (COST_W + 1)'(item_reg.edge_weight);
    assign left_dec  = (nodes_left_reg > NODE_W'(1)) ? nodes_left_reg - NODE_W'(1)
                                                     : nodes_left_reg;

    assign res_data.edge_taken    = taken_reg;
    assign res_data.tree_complete = done_reg;
    assign res_data.running_cost  = cost_reg;
    assign res_data.final_cost    = (item_reg.last_edge && done_reg) ? cost_reg : '0;
    assign res_data.is_final      = item_reg.last_edge;

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        nodes_left_next = nodes_left_reg;
        cost_next       = cost_reg;
        done_next       = done_reg;
        item_next       = item_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        root_a_next     = root_a_reg;
        side_next       = side_reg;
        taken_next      = taken_reg;
        edge_ready      = 1'b0;
        res_load        = 1'b0;
        tbl_req         = '0;
        tbl_req.rd_node = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                edge_ready = !cfg_valid;
                if (cfg_we)
                begin
                    node_count_next = cfg_data;
                    nodes_left_next = eff_cfg;
                    cost_next       = '0;
                    done_next       = (eff_cfg <= NODE_W'(1));
                    tbl_req.clear   = 1'b1;
                end
                else if (edge_valid)
                begin
                    item_next  = edge_req;
                    taken_next = 1'b0;
                    cur_next   = edge_req.from_node;
                    side_next  = 1'b0;
                    state_next = (!done_reg && in_range) ? ST_FIND_ISSUE : ST_OUTPUT;
                end
            end

            ST_FIND_ISSUE:
            begin
                state_next = ST_FIND_WALK;
            end

            ST_FIND_WALK:
            begin
                if (tbl_parent == cur_reg)
                begin
                    root_next  = cur_reg;
                    cur_next   = side_reg ? item_reg.to_node : item_reg.from_node;
                    state_next = ST_COMP_ISSUE;
                end
                else
                begin
                    cur_next        = tbl_parent;
                    tbl_req.rd_node = tbl_parent;
                end
            end

            ST_COMP_ISSUE:
            begin
                state_next = ST_COMP_WALK;
            end

            ST_COMP_WALK:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!side_reg)
                    begin
                        root_a_next = root_reg;
                        side_next   = 1'b1;
                        cur_next    = item_reg.to_node;
                        state_next  = ST_FIND_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_UNION;
                    end
                end
                else
                begin
                    // Point this node at the root and step to its old parent.
                    tbl_req.wr_en     = 1'b1;
                    tbl_req.wr_node   = cur_reg;
                    tbl_req.wr_parent = root_reg;
                    cur_next          = tbl_parent;
                    tbl_req.rd_node   = tbl_parent;
                end
            end

            ST_UNION:
            begin
                if (root_a_reg != root_reg)
                begin
                    tbl_req.wr_en = 1'b1;
                    if (root_a_reg > root_reg)
                    begin
                        tbl_req.wr_node   = root_a_reg;
                        tbl_req.wr_parent = root_reg;
                    end
                    else
                    begin
                        tbl_req.wr_node   = root_reg;
                        tbl_req.wr_parent = root_a_reg;
                    end
                    taken_next      = 1'b1;
                    cost_next       = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
                    nodes_left_next = left_dec;
                    done_next       = (left_dec <= NODE_W'(1));
                end
                state_next = ST_OUTPUT;
            end

            ST_OUTPUT:
            begin
                if (slot_free)
                begin
                    res_load = 1'b1;
                    if (item_reg.last_edge)
                    begin
                        nodes_left_next = eff_cur;
                        cost_next       = '0;
                        done_next       = (eff_cur <= NODE_W'(1));
                        tbl_req.clear   = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= RESET_NODES;
            nodes_left_reg <= eff_nodes(RESET_NODES);
            cost_reg       <= '0;
            done_reg       <= (eff_nodes(RESET_NODES) <= NODE_W'(1));
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            nodes_left_reg <= nodes_left_next;
            cost_reg       <= cost_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        side_reg   <= side_next;
        taken_reg  <= taken_next;
    end

endmodule

[rtl/core/kruskal_union_find_mst.sv]
// ============================================================================
// kruskal_union_find_mst: Kruskal spanning tree accumulator
// Union-find over a parent table with path compression, one edge per
// request, one result per edge, held in an output register.
// ============================================================================
// Edges arrive one request at a time, and the user must keep them in
// nondecreasing weight order; the block itself does not enforce this. For
// each edge the block finds the roots of both endpoints, compresses both
// paths, and if the roots differ points the larger root at the smaller one
// and adds the weight to a cost that saturates at its 22-bit maximum. Once
// the effective node count minus one edges have been taken the tree is
// complete and later edges are ignored. The result of an edge marked last
// carries the final cost (zero if the graph was not spanned), and the table
// and counters then start over for a new graph; a write of node_count starts
// a new graph as well. Each endpoint's parent chain is walked once to find
// its root and once more to compress it, through the single registered read
// port of the parent table, which moves one hop per cycle through the shared
// node compare. An edge that is out of range or arrives after completion
// skips the walks. Path compression keeps chains short. The input is not
// ready while an edge is in work; the result register lets the next edge be
// accepted while a result still waits.
module kruskal_union_find_mst
    import kufm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NODE_W-1:0] cfg_data,
    input  logic              edge_valid,
    output logic              edge_ready,
    input  edge_t             edge_req,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    tbl_req_t          tbl_req;
    logic [NODE_W-1:0] tbl_parent;
    logic              res_load;
    result_t           res_data;
    logic              slot_free;
    logic              res_valid_reg;
    result_t           res_reg;

    // The output register can take a new result when it is empty or is being
    // drained in this cycle.
    assign slot_free = !res_valid_reg || res_ready;

    kufm_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tbl_req),
        .parent (tbl_parent)
    );

    kufm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .edge_valid (edge_valid),
        .edge_ready (edge_ready),
        .edge_req   (edge_req),
        .slot_free  (slot_free),
        .res_load   (res_load),
        .res_data   (res_data),
        .tbl_req    (tbl_req),
        .tbl_parent (tbl_parent)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_data;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> slot_free)
        else $error("result loaded while the output register was full");

    // After an edge request is accepted the block is not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_valid && edge_ready) |=> !edge_ready)
        else $error("edge accepted while the previous one was in work");

    // A nonzero final cost only appears on the last edge of a complete tree.
    a_final_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.final_cost != '0)) |-> (res.is_final && res.tree_complete))
        else $error("final cost reported outside a completed last edge");
`endif

endmodule

[bench/tb_kruskal_union_find_mst.sv]
// ----------------------------------------------------------------------------
// tb_kruskal_union_find_mst: self-checking bench for the spanning tree block
// Streams graphs of edges into the block and checks every result against a
// union-find predictor kept inside the bench. Graphs come in several sizes,
// with some broken and noisy graphs mixed in, under changing flow control.
// ----------------------------------------------------------------------------
module tb_kruskal_union_find_mst;
    import kufm_pkg::*;

    // Upper bound on simulated time, with a wide margin over a correct run.
    localparam int RUN_LIMIT = 10_000_000;

    // Cycles to keep watching the result port once everything is drained.
    localparam int DRAIN_CYCLES = 200;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [NODE_W-1:0] cfg_data = '0;
    logic              edge_valid = 1'b0;
    logic              edge_ready;
    edge_t             edge_req = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    result_t           res;

    // Requests waiting to be sent, and the results predicted for the
    // requests the block has already accepted, oldest first.
    edge_t   pending_edges [$];
    result_t expected_results [$];

    // Counters used to tell when the block has gone idle. Both are written
    // at the rising edge only, so reading them at the falling edge is safe.
    int edges_queued = 0;
    int results_seen = 0;
    int error_count = 0;

    // Percent chance per cycle that the sender holds back or the receiver
    // stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Set at a rising edge when the edge request was taken, so the driver
    // knows at the next falling edge whether it may present a new one.
    logic edge_hs = 1'b0;

    // Predictor state: the union-find table, the number of sets still to be
    // joined before the tree is complete, the cost so far and the done flag.
    logic [NODE_W-1:0] parent_of [0:MAX_NODES];
    logic [NODE_W-1:0] node_count_reg;
    int                nodes_unjoined;
    int                tree_cost;
    bit                tree_done;

    kruskal_union_find_mst u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .edge_valid (edge_valid),
        .edge_ready (edge_ready),
        .edge_req   (edge_req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A node count of zero behaves as one node, and anything above the table
    // size behaves as a full table.
    function automatic int eff_count(input int value);
        if (value == 0)
            return 1;
        if (value > MAX_NODES)
            return MAX_NODES;
        return value;
    endfunction

    // Every node becomes its own root again and the cost starts from zero.
    // With a single node there is nothing to join, so the tree is complete
    // straight away.
    function automatic void restart_graph();
        int i;
        for (i = 0; i <= MAX_NODES; i++)
            parent_of[i] = NODE_W'(i);
        nodes_unjoined = eff_count(int'(node_count_reg));
        tree_cost = 0;
        tree_done = (nodes_unjoined <= 1);
    endfunction

    // Follows the parent links up to the root, then points every node on the
    // way straight at that root.
    function automatic int find_root(input int node);
        int r;
        int cur;
        int nxt;
        int hops;
        r = node;
        hops = 0;
        while (r <= MAX_NODES && int'(parent_of[r]) != r && hops < MAX_NODES)
        begin
            r = parent_of[r];
            hops++;
        end
        if (r > MAX_NODES)
            r = node;
        cur = node;
        hops = 0;
        while (cur <= MAX_NODES && cur != r && hops < MAX_NODES)
        begin
            nxt = parent_of[cur];
            parent_of[cur] = NODE_W'(r);
            cur = nxt;
            hops++;
        end
        return r;
    endfunction

    // Applies one edge to the predictor and returns the result it should
    // produce. An edge is only considered while the tree is still open and
    // both endpoints are real nodes; it is taken when its endpoints sit in
    // different sets, and the larger root then hangs under the smaller one.
    function automatic result_t predict_tree_step(input edge_t e);
        result_t r;
        int      n;
        int      root_a;
        int      root_b;
        int      sum;
        bit      took;
        n = eff_count(int'(node_count_reg));
        took = 1'b0;
        if (!tree_done && e.from_node >= 1 && e.from_node <= n
            && e.to_node >= 1 && e.to_node <= n)
        begin
            root_a = find_root(int'(e.from_node));
            root_b = find_root(int'(e.to_node));
            if (root_a != root_b)
            begin
                if (root_a > root_b)
                    parent_of[root_a] = NODE_W'(root_b);
                else
                    parent_of[root_b] = NODE_W'(root_a);
                took = 1'b1;
                // The cost saturates rather than wrapping.
                sum = tree_cost + int'(e.edge_weight);
                tree_cost = (sum > int'(COST_MAX)) ? int'(COST_MAX) : sum;
                if (nodes_unjoined > 1)
                    nodes_unjoined--;
                if (nodes_unjoined <= 1)
                    tree_done = 1'b1;
            end
        end
        r.edge_taken    = took;
        r.tree_complete = tree_done;
        r.running_cost  = COST_W'(tree_cost);
        r.final_cost    = (e.last_edge && tree_done) ? COST_W'(tree_cost) : '0;
        r.is_final      = e.last_edge;
        // The closing edge of a graph hands over to a fresh graph.
        if (e.last_edge)
            restart_graph();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Monitor: samples both handshakes at the rising edge. Results are
    // checked before a new request is predicted, so a result can never be
    // matched against a request accepted in the same cycle. A register write
    // restarts the graph in the predictor just as it does in the block.
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            node_count_reg = RESET_NODES;
            restart_graph();
            edge_hs <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_error("result arrived with no edge request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("edge_taken", int'(res.edge_taken),
                                int'(want.edge_taken));
                    check_field("tree_complete", int'(res.tree_complete),
                                int'(want.tree_complete));
                    check_field("running_cost", int'(res.running_cost),
                                int'(want.running_cost));
                    check_field("final_cost", int'(res.final_cost),
                                int'(want.final_cost));
                    check_field("is_final", int'(res.is_final),
                                int'(want.is_final));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg = cfg_data;
                restart_graph();
            end
            if (edge_valid && edge_ready)
                expected_results.push_back(predict_tree_step(edge_req));
            edge_hs <= edge_valid && edge_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------

    // Inputs move at the falling edge. A request stays on the port until the
    // monitor has seen it taken; only then may the next one be presented or
    // the sender go idle.
    always @(negedge clk)
    begin
        if (!rst_n)
            edge_valid <= 1'b0;
        else if (!edge_valid || edge_hs)
        begin
            if (pending_edges.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                edge_req <= pending_edges.pop_front();
                edge_valid <= 1'b1;
            end
            else
                edge_valid <= 1'b0;
        end
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_edge(input int from_n, input int to_n, input int weight,
                              input bit last);
        edge_t e;
        e.from_node   = NODE_W'(from_n);
        e.to_node     = NODE_W'(to_n);
        e.edge_weight = WEIGHT_W'(weight);
        e.last_edge   = last;
        pending_edges.push_back(e);
        edges_queued++;
    endtask

    // An endpoint for a noisy edge: half the time near the valid range,
    // including zero and one past the end, otherwise anywhere in the field.
    function automatic int pick_node(input int n);
        if ($urandom_range(1) == 0)
            return $urandom_range(0, n + 1);
        return $urandom_range(0, 127);
    endfunction

    // Queues one graph for n effective nodes. Most graphs are built to span:
    // the nodes are shuffled and each one is tied to a node earlier in the
    // order, with redundant edges, a little noise, and a few edges after
    // completion mixed in. Some graphs stop short of spanning, a few use
    // weights near the top of the field, and a few are pure noise with
    // unordered weights.
    task automatic queue_graph(input int n);
        int order [$];
        int ends_a [$];
        int ends_b [$];
        int style;
        int stop_at;
        int i;
        int j;
        int swap;
        int w;
        style = $urandom_range(0, 9);
        for (i = 1; i <= n; i++)
            order.push_back(i);
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        if (style == 0)
        begin
            for (i = $urandom_range(1, 8); i > 0; i--)
            begin
                ends_a.push_back(pick_node(n));
                ends_b.push_back(pick_node(n));
            end
        end
        else
        begin
            stop_at = (style == 1 && n >= 2) ? $urandom_range(1, n - 1) : n;
            for (i = 1; i < stop_at; i++)
            begin
                if ($urandom_range(99) < 30)
                begin
                    ends_a.push_back($urandom_range(1, n));
                    ends_b.push_back($urandom_range(1, n));
                end
                if ($urandom_range(99) < 4)
                begin
                    ends_a.push_back(pick_node(n));
                    ends_b.push_back(pick_node(n));
                end
                j = $urandom_range(0, i - 1);
                if ($urandom_range(1) == 0)
                begin
                    ends_a.push_back(order[i]);
                    ends_b.push_back(order[j]);
                end
                else
                begin
                    ends_a.push_back(order[j]);
                    ends_b.push_back(order[i]);
                end
            end
            for (i = $urandom_range(0, 3); i > 0; i--)
            begin
                ends_a.push_back($urandom_range(1, n));
                ends_b.push_back($urandom_range(1, n));
            end
        end
        if (ends_a.size() == 0)
        begin
            ends_a.push_back($urandom_range(1, n));
            ends_b.push_back($urandom_range(1, n));
        end
        // Weights climb in small steps so the graph arrives sorted, except in
        // the noise graphs.
        w = (style == 9) ? $urandom_range(60000, 65535) : $urandom_range(0, 1000);
        for (i = 0; i < ends_a.size(); i++)
        begin
            if (style == 0)
                w = $urandom_range(0, 65535);
            else if (i != 0)
            begin
                w = w + $urandom_range(0, 1500);
                if (w > 65535)
                    w = 65535;
            end
            queue_edge(ends_a[i], ends_b[i], w, i == ends_a.size() - 1);
        end
    endtask

    // Returns at a falling edge once every queued request has produced its
    // result, which is when the register may be written.
    task automatic wait_drained();
        @(negedge clk);
        while (results_seen != edges_queued)
            @(negedge clk);
    endtask

    // Writes node_count. Called at a falling edge with the block idle, and
    // returns at a rising edge so new requests are queued deterministically.
    task automatic write_node_count(input int value);
        cfg_data <= NODE_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int idle_phase;
        int phase_start;
        int chunk_start;
        int chunk;
        int cfg_value;
        int pick;

        send_idle_pct = 28;
        recv_stall_pct = 66;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks at the reset node count of 64: a taken edge, the
        // same pair reversed, a self loop, endpoints of zero, just past the
        // range and at the top of the field, a maximum weight, and a closing
        // edge on a graph that never spanned.
        queue_edge(1, 64, 0, 1'b0);
        queue_edge(64, 1, 5, 1'b0);
        queue_edge(7, 7, 9, 1'b0);
        queue_edge(0, 3, 10, 1'b0);
        queue_edge(65, 2, 11, 1'b0);
        queue_edge(127, 127, 12, 1'b0);
        queue_edge(2, 64, 65535, 1'b0);
        queue_edge(3, 0, 65535, 1'b1);

        // One node: the tree is complete before any edge arrives.
        wait_drained();
        write_node_count(1);
        queue_edge(1, 1, 100, 1'b0);
        queue_edge(1, 1, 65535, 1'b1);

        // A node count of zero behaves as one node.
        wait_drained();
        write_node_count(0);
        queue_edge(2, 1, 3, 1'b0);
        queue_edge(1, 1, 7, 1'b1);

        // Two nodes: one edge completes the tree, and the next is ignored.
        wait_drained();
        write_node_count(2);
        queue_edge(2, 1, 65535, 1'b0);
        queue_edge(1, 2, 65535, 1'b0);
        queue_edge(3, 3, 0, 1'b1);

        // A count above the table size behaves as a full table.
        wait_drained();
        write_node_count(65);
        queue_edge(64, 63, 1, 1'b0);
        queue_edge(63, 64, 1, 1'b1);

        // Random graphs under three flow control settings. Every stretch
        // starts with a register write, mostly to small node counts so that
        // many graphs complete, with the extremes mixed in.
        for (idle_phase = 0; idle_phase < 3; idle_phase++)
        begin
            phase_start = edges_queued;
            chunk = 0;
            while (edges_queued - phase_start < 330)
            begin
                wait_drained();
                if (idle_phase == 0)
                begin
                    send_idle_pct = 28;
                    recv_stall_pct = 66;
                end
                else if (idle_phase == 1)
                begin
                    send_idle_pct = 66;
                    recv_stall_pct = 28;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                pick = $urandom_range(99);
                if (chunk == 0)
                    cfg_value = (idle_phase == 0) ? 127 : (idle_phase == 1) ? 64 : 0;
                else if (pick < 70)
                    cfg_value = $urandom_range(2, 12);
                else if (pick < 80)
                    cfg_value = $urandom_range(13, 40);
                else if (pick < 90)
                    cfg_value = $urandom_range(0, 1);
                else
                    cfg_value = $urandom_range(65, 127);
                write_node_count(cfg_value);
                chunk_start = edges_queued;
                while (edges_queued - chunk_start < 50)
                    queue_graph(eff_count(cfg_value));
                chunk++;
            end
        end

        // Let everything drain, then keep watching for stray results.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog in case the block hangs.
    initial
    begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
